/* hdl/nvn_pkg.sv */
// shared widths and types for the vector normalizer
package nvn_pkg;

    localparam int COMP_W   = 24;
    localparam int SQ_W     = 48;
    localparam int ROOT_W   = 24;
    localparam int SREM_W   = 26;
    localparam int DREM_W   = 25;
    localparam int Q_W      = 17;
    localparam int OUT_W    = 18;
    localparam int SQ_STEPS = 24;
    localparam int DV_STEPS = 17;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'd65536;

    localparam logic [2:0] ADDR_MIN_LENGTH = 3'd0;

    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][COMP_W-1:0] mag;
    } nvn_vec_t;

    typedef struct packed {
        logic [2:0]        neg;
        logic              flag;
        logic [ROOT_W-1:0] len;
    } nvn_div_side_t;

endpackage

/* hdl/nvn_sqrt_cell.sv */
// one digit step of the pipelined square root
module nvn_sqrt_cell
    import nvn_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SREM_W-1:0] rem_in,
    input  logic [ROOT_W-1:0] root_in,
    input  logic [SQ_W-1:0]   n_in,
    output logic [SREM_W-1:0] rem_reg,
    output logic [ROOT_W-1:0] root_reg,
    output logic [SQ_W-1:0]   n_reg
);

    logic [SREM_W+1:0] cur;
    logic [SREM_W+1:0] trial;
    logic [SREM_W-1:0] rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        cur   = {rem_in, n_in[SQ_W-1 -: 2]};
        trial = {root_in, 2'b01};
        if (cur >= trial)
        begin
            rem_next  = SREM_W'(cur - trial);
            root_next = {root_in[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = cur[SREM_W-1:0];
            root_next = {root_in[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            n_reg    <= {n_in[SQ_W-3:0], 2'b00};
        end
    end

endmodule

/* hdl/nvn_div_cell.sv */
// one quotient bit of the pipelined restoring divider
module nvn_div_cell
    import nvn_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DREM_W-1:0] rem_in,
    input  logic [Q_W-1:0]    q_in,
    input  logic              nbit,
    input  logic [ROOT_W-1:0] len,
    output logic [DREM_W-1:0] rem_reg,
    output logic [Q_W-1:0]    q_reg
);

    logic [DREM_W:0]   cur;
    logic [DREM_W-1:0] rem_next;
    logic [Q_W-1:0]    q_next;

    always_comb
    begin
        cur = {rem_in, nbit};
        if (cur >= (DREM_W+1)'(len))
        begin
            rem_next = DREM_W'(cur - (DREM_W+1)'(len));
            q_next   = {q_in[Q_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = cur[DREM_W-1:0];
            q_next   = {q_in[Q_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

endmodule

/* hdl/vector3_normalize_top.sv */
// top level of the 3-component vector normalizer
// Usage: a vector (x, y, z, signed Q8.16) enters on the s_ stream group and
// leaves as a unit vector (signed Q2.16) on the m_ group, one result per
// transfer in, in order. m_tuser is set when the length exceeded min_length;
// otherwise the three components are zero.
// min_length is written over APB at byte address 0; the user must do so
// only while idle; the block does not check. Stages: magnitude, square and
// sum registers, 24 square-root cells, a setup register, 17 divider cells,
// an output register. Throughput: one vector per cycle while s_tready is
// high; each root and divider cell hands on its partial result when enabled.
// When the receiver stalls, a skid register takes the one result in flight,
// then s_tready drops and the whole chain holds until m_tready returns.
// Reset clears all valid bits and min_length; results in flight are lost.
module vector3_normalize_top
    import nvn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // in_x, in_y, in_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // unit_x, unit_y, unit_z, zero pad
    output logic        m_tuser,   // was_normalized
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [COMP_W-1:0] min_length_reg;
    logic              en;

    // configuration
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_MIN_LENGTH[2]) ? {8'd0, min_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_length_reg <= '0;
        else if (psel && penable && pwrite && pready && paddr[2] == ADDR_MIN_LENGTH[2])
            min_length_reg <= pwdata[COMP_W-1:0];
    end

    // magnitude, square and sum stages
    logic                          a_valid_reg, b_valid_reg, c_valid_reg;
    nvn_vec_t                      a_vec_reg, b_vec_reg, c_vec_reg, a_vec_next;
    logic [2:0][SQ_W-1:0]          b_sq_reg;
    logic [SQ_W-1:0]               c_sum_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_vec_next.neg[i] = s_tdata[i*COMP_W + COMP_W-1];
            a_vec_next.mag[i] = s_tdata[i*COMP_W + COMP_W-1]
                ? COMP_W'(~s_tdata[i*COMP_W +: COMP_W] + 1'b1)
                : s_tdata[i*COMP_W +: COMP_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_vec_reg <= a_vec_next;
            b_vec_reg <= a_vec_reg;
            for (int i = 0; i < 3; i++)
                b_sq_reg[i] <= a_vec_reg.mag[i] * a_vec_reg.mag[i];
            c_vec_reg <= b_vec_reg;
            c_sum_reg <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // square root chain
    logic [SQ_STEPS:0]             sq_valid;
    nvn_vec_t                      sq_vec  [SQ_STEPS+1];
    logic [SREM_W-1:0]             sq_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0]             sq_root [SQ_STEPS+1];
    logic [SQ_W-1:0]               sq_n    [SQ_STEPS+1];

    assign sq_valid[0] = c_valid_reg;
    assign sq_vec[0]   = c_vec_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_n[0]     = c_sum_reg;

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        nvn_sqrt_cell u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .n_in     (sq_n[k]),
            .rem_reg  (sq_rem[k+1]),
            .root_reg (sq_root[k+1]),
            .n_reg    (sq_n[k+1])
        );

        logic     valid_reg;
        nvn_vec_t vec_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= sq_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                vec_reg <= sq_vec[k];
        end

        assign sq_valid[k+1] = valid_reg;
        assign sq_vec[k+1]   = vec_reg;
    end

    // divider setup
    logic                    d0_valid_reg;
    nvn_div_side_t           d0_side_reg;
    logic [2:0][DREM_W-1:0]  d0_rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d0_valid_reg <= 1'b0;
        else if (en)
            d0_valid_reg <= sq_valid[SQ_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_side_reg.neg  <= sq_vec[SQ_STEPS].neg;
            d0_side_reg.len  <= sq_root[SQ_STEPS];
            d0_side_reg.flag <= sq_root[SQ_STEPS] > min_length_reg;
            for (int i = 0; i < 3; i++)
                d0_rem_reg[i] <= DREM_W'(sq_vec[SQ_STEPS].mag[i] >> 1);
        end
    end

    // divider chain
    logic [DV_STEPS:0]         dv_valid;
    nvn_div_side_t             dv_side [DV_STEPS+1];
    logic [2:0][DREM_W-1:0]    dv_rem  [DV_STEPS+1];
    logic [2:0][Q_W-1:0]       dv_q    [DV_STEPS+1];
    logic [2:0]                d0_lsb;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            d0_lsb[i] = 1'b0;
    end

    assign dv_valid[0] = d0_valid_reg;
    assign dv_side[0]  = d0_side_reg;
    assign dv_rem[0]   = d0_rem_reg;
    assign dv_q[0]     = '0;

    // mag lsb is the first numerator bit brought in; later bits are zero
    logic [2:0] mag_lsb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            for (int i = 0; i < 3; i++)
                mag_lsb_reg[i] <= sq_vec[SQ_STEPS].mag[i][0];
    end

    for (genvar k = 0; k < DV_STEPS; k++)
    begin : g_div
        for (genvar c = 0; c < 3; c++)
        begin : g_comp
            nvn_div_cell u_cell (
                .clk     (clk),
                .en      (en),
                .rem_in  (dv_rem[k][c]),
                .q_in    (dv_q[k][c]),
                .nbit    ((k == 0) ? mag_lsb_reg[c] : d0_lsb[c]),
                .len     (dv_side[k].len),
                .rem_reg (dv_rem[k+1][c]),
                .q_reg   (dv_q[k+1][c])
            );
        end

        logic          valid_reg;
        nvn_div_side_t side_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else if (en)
                valid_reg <= dv_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                side_reg <= dv_side[k];
        end

        assign dv_valid[k+1] = valid_reg;
        assign dv_side[k+1]  = side_reg;
    end

    // clamp, sign and zeroing
    logic [3*OUT_W:0] res_next;
    logic [Q_W-1:0]   qc;

    always_comb
    begin
        res_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            qc = (dv_q[DV_STEPS][i] > ONE_Q16) ? ONE_Q16 : dv_q[DV_STEPS][i];
            if (dv_side[DV_STEPS].flag)
                res_next[i*OUT_W +: OUT_W] = dv_side[DV_STEPS].neg[i]
                    ? OUT_W'(~OUT_W'(qc) + 1'b1) : OUT_W'(qc);
        end
        res_next[3*OUT_W] = dv_side[DV_STEPS].flag;
    end

    // output register and skid
    logic             out_valid_reg, skid_valid_reg;
    logic [3*OUT_W:0] out_data_reg, skid_data_reg;
    logic             out_free;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (dv_valid[DV_STEPS])
        begin
            if (out_free)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
                out_data_reg <= skid_data_reg;
        end
        else if (dv_valid[DV_STEPS])
        begin
            if (out_free)
                out_data_reg <= res_next;
            else
                skid_data_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg[3*OUT_W-1:0]};
    assign m_tuser  = out_data_reg[3*OUT_W];

    // checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_zero_when_flat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 56'd0))
        else $error("unnormalized result is not zero");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[17:0]) <= 18'sd65536 &&
                      $signed(m_tdata[17:0]) >= -18'sd65536))
        else $error("x component out of unit range");

    a_hold_on_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_free) |=> skid_valid_reg)
        else $error("skid result dropped");

endmodule

/* tb/tb.sv */
// testbench for the vector normalizer: directed and random vectors checked against a local model
module tb;
    import nvn_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;      // in_x, in_y, in_z
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;           // unit_x, unit_y, unit_z, zero pad
    logic        m_tuser;           // was_normalized
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    typedef struct packed {
        logic              normed;
        logic [OUT_W-1:0]  uz;
        logic [OUT_W-1:0]  uy;
        logic [OUT_W-1:0]  ux;
    } unit_vec_t;

    unit_vec_t   unit_queue[$];
    logic [23:0] threshold = '0;
    int          mismatches = 0;
    int          sent = 0;
    int          received = 0;
    int          normed_count = 0;
    longint      cycles = 0;
    bit          stall_enable = 1'b1;

    vector3_normalize_top DUT (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic logic [23:0] magnitude(input logic [23:0] c);
        return c[23] ? (~c + 24'd1) : c;
    endfunction

    function automatic logic [23:0] floor_root(input logic [47:0] n);
        logic [23:0] r;
        logic [23:0] t;
        r = '0;
        for (int b = 23; b >= 0; b--)
        begin
            t = r | (24'd1 << b);
            if (48'(t) * 48'(t) <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] unit_comp(input logic [23:0] c, input logic [23:0] len);
        logic [47:0] q;
        q = {8'd0, magnitude(c), 16'd0} / 48'(len);
        if (q > 48'd65536)
            q = 48'd65536;
        return c[23] ? OUT_W'(-q) : OUT_W'(q);
    endfunction

    function automatic unit_vec_t normalize(input logic [71:0] v);
        unit_vec_t   r;
        logic [47:0] sum;
        logic [23:0] len;
        sum = 48'(magnitude(v[23:0])) * magnitude(v[23:0])
            + 48'(magnitude(v[47:24])) * magnitude(v[47:24])
            + 48'(magnitude(v[71:48])) * magnitude(v[71:48]);
        len = floor_root(sum);
        r = '0;
        if (len > threshold)
        begin
            r.ux = unit_comp(v[23:0], len);
            r.uy = unit_comp(v[47:24], len);
            r.uz = unit_comp(v[71:48], len);
            r.normed = 1'b1;
        end
        return r;
    endfunction

    task automatic send_vector(input logic [23:0] x, input logic [23:0] y, input logic [23:0] z);
        int gap;
        gap = stall_enable ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        unit_queue.push_back(normalize({z, y, x}));
        sent++;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (unit_queue.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [23:0] val, input logic [2:0] addr);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= {8'($urandom), val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_MIN_LENGTH)
            threshold = val;
    endtask

    // receiver with random stalls
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            unit_vec_t got;
            got = {m_tuser, m_tdata[53:36], m_tdata[35:18], m_tdata[17:0]};
            received++;
            if (m_tuser)
                normed_count++;
            if (unit_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer %h", got);
            end
            else
            begin
                unit_vec_t want;
                want = unit_queue.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h f=%b got x=%h y=%h z=%h f=%b",
                                 want.ux, want.uy, want.uz, want.normed,
                                 got.ux, got.uy, got.uz, got.normed);
                end
            end
        end
        m_tready <= !stall_enable || ($urandom_range(0, 13) < 7);
    end

    function automatic logic [23:0] random_comp();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 40)) - 24'd20;
            1: return 24'h7FFFFF;
            2: return 24'h800000;
            3: return 24'($urandom_range(0, 65535 * 2)) - 24'd65535;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_extremes;
        send_vector(0, 0, 0);
        send_vector(24'h7FFFFF, 0, 0);
        send_vector(24'h800000, 0, 0);
        send_vector(0, 24'h800000, 0);
        send_vector(0, 0, 24'h7FFFFF);
        send_vector(24'h800000, 24'h800000, 24'h800000);
        send_vector(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_vector(24'h7FFFFF, 24'h800000, 24'h000001);
        send_vector(24'd1, 0, 0);
        send_vector(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_vector(24'd65536, 24'hFF0000, 24'd3);
        send_vector(24'h555555, 24'hAAAAAA, 24'h123456);
    endtask

    task automatic test_threshold;
        // vectors at and around several thresholds, extremes included
        write_threshold(24'd65536, ADDR_MIN_LENGTH);
        send_vector(24'd65536, 0, 0);
        send_vector(24'd65537, 0, 0);
        send_vector(24'hFEFFFF, 0, 0);
        write_threshold(24'hFFFFFF, ADDR_MIN_LENGTH);
        send_vector(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_vector(24'h800000, 24'h800000, 24'h800000);
        // write to another address is ignored
        write_threshold(24'd0, 3'd4);
        send_vector(24'd5, 0, 0);
        write_threshold(24'd0, ADDR_MIN_LENGTH);
        send_vector(24'd1, 24'd1, 0);
    endtask

    task automatic test_random;
        logic [23:0] levels[4];
        levels = '{24'd0, 24'd300, 24'd65536, 24'd3000000};
        for (int p = 0; p < 4; p++)
        begin
            write_threshold(levels[p], ADDR_MIN_LENGTH);
            stall_enable = (p != 2);
            for (int i = 0; i < 125; i++)
                send_vector(random_comp(), random_comp(), random_comp());
        end
        stall_enable = 1'b1;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_threshold();
        test_random();
        drain();
        $display("sent %0d vectors, %0d results, %0d normalized", sent, received, normed_count);
        $display("thresholds from zero to full scale, with and without stalls");
        if (mismatches == 0 && unit_queue.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

/* files.f */
hdl/nvn_pkg.sv
hdl/nvn_sqrt_cell.sv
hdl/nvn_div_cell.sv
hdl/vector3_normalize_top.sv
tb/tb.sv
